FILE: src/hrc_pkg.sv
package hrc_pkg;

    // Default width of the run length and output offset counters
    localparam int unsigned COUNT_WIDTH_DEFAULT = 32;

    // Cutoff after reset: runs of two or more bases collapse
    localparam logic [31:0] CUTOFF_RESET = 32'd1;

    // Result queue: room for the two records that one base can close
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] base;
        logic       end_of_sequence;
    } t_in;

    typedef struct packed {
        logic [7:0]  run_base;
        logic [31:0] original_length;
        logic [31:0] emitted_length;
        logic        collapsed;
        logic [31:0] compressed_position;
        logic        last_run;
    } t_out;

    // Records produced by one accepted base, in delivery order
    typedef struct packed {
        logic push_a;
        logic push_b;
        t_out rec_a;
        t_out rec_b;
    } t_push;

endpackage

FILE: src/homopolymer_run_compressor.sv
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_data   (hrc_pkg::t_in)
// out       output     o_out_valid / i_out_ready  o_out_data  (hrc_pkg::t_out)
// cfg       input      i_cfg_we (no wait)         i_cfg_wdata (run cutoff)
//
// One base is taken per cycle while the input is ready. The run state updates
// in the cycle of the transfer; its records enter a four-entry result queue
// and show on the output from the next cycle on. The output drains one record
// per cycle while the consumer is ready, so a base that closes two runs takes
// two transfers out. The input is ready whenever the queue has two free slots.
// Reset (synchronous, active low) clears the run state, the offset and the queue and sets the cutoff to one.
module homopolymer_run_compressor #(
    parameter int unsigned COUNT_WIDTH = hrc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hrc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hrc_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata
);

    logic           in_xfer;
    hrc_pkg::t_push push;

    // an input transfer needs room for both records it may close
    assign in_xfer = i_in_valid && o_in_ready;

    // run tracking: compare the base, advance the length, close runs
    hrc_tracker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_xfer),
        .i_item      (i_in_data),
        .o_push      (push)
    );

    // hold finished records until the consumer takes them
    hrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

FILE: src/hrc_tracker.sv
module hrc_tracker #(
    parameter int unsigned COUNT_WIDTH = hrc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_accept,
    input  hrc_pkg::t_in i_item,
    output hrc_pkg::t_push o_push
);

    localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    logic [31:0]            r_cutoff;
    logic [7:0]             r_base;
    logic [COUNT_WIDTH-1:0] r_len;
    logic [COUNT_WIDTH-1:0] r_offset;
    logic                   r_open;

    logic [7:0]             n_base;
    logic [COUNT_WIDTH-1:0] n_len;
    logic [COUNT_WIDTH-1:0] n_offset;
    logic                   n_open;

    logic                   split;
    logic                   coll_a;
    logic                   coll_b;
    logic [COUNT_WIDTH-1:0] emit_a;
    logic [COUNT_WIDTH-1:0] emit_b;
    logic [COUNT_WIDTH-1:0] len_b;
    logic [COUNT_WIDTH-1:0] off_b;

    always_comb begin
        split  = r_open && (i_item.base != r_base);

        // record of the run closed by a differing base
        coll_a = CMP_WIDTH'(r_len) > CMP_WIDTH'(r_cutoff);
        emit_a = coll_a ? COUNT_WIDTH'(1) : r_len;

        // run holding the incoming base
        len_b  = (r_open && !split) ? r_len + COUNT_WIDTH'(1) : COUNT_WIDTH'(1);
        off_b  = split ? r_offset + emit_a : r_offset;
        coll_b = CMP_WIDTH'(len_b) > CMP_WIDTH'(r_cutoff);
        emit_b = coll_b ? COUNT_WIDTH'(1) : len_b;

        o_push.push_a = i_accept && split;
        o_push.push_b = i_accept && i_item.end_of_sequence;

        o_push.rec_a.run_base            = r_base;
        o_push.rec_a.original_length     = 32'(r_len);
        o_push.rec_a.emitted_length      = 32'(emit_a);
        o_push.rec_a.collapsed           = coll_a;
        o_push.rec_a.compressed_position = 32'(r_offset);
        o_push.rec_a.last_run            = 1'b0;

        o_push.rec_b.run_base            = i_item.base;
        o_push.rec_b.original_length     = 32'(len_b);
        o_push.rec_b.emitted_length      = 32'(emit_b);
        o_push.rec_b.collapsed           = coll_b;
        o_push.rec_b.compressed_position = 32'(off_b);
        o_push.rec_b.last_run            = 1'b1;

        // end of sequence drops the run and restarts the offset
        if (i_item.end_of_sequence) begin
            n_open   = 1'b0;
            n_base   = 8'd0;
            n_len    = '0;
            n_offset = '0;
        end else begin
            n_open   = 1'b1;
            n_base   = i_item.base;
            n_len    = len_b;
            n_offset = off_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= hrc_pkg::CUTOFF_RESET;
            r_open   <= 1'b0;
            r_base   <= 8'd0;
            r_len    <= '0;
            r_offset <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cutoff <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_open   <= n_open;
                r_base   <= n_base;
                r_len    <= n_len;
                r_offset <= n_offset;
            end
        end
    end

endmodule

FILE: src/hrc_queue.sv
module hrc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hrc_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output hrc_pkg::t_out  o_data
);

    localparam int unsigned AW = hrc_pkg::QUEUE_AW;
    localparam int unsigned CW = AW + 1;

    hrc_pkg::t_out r_mem [hrc_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic [AW-1:0] n_wr_ptr;
    logic [CW-1:0] n_count;
    logic [CW-1:0] push_cnt;
    logic          pop;
    logic          any_push;
    hrc_pkg::t_out first_rec;

    always_comb begin
        pop       = (r_count != '0) && i_ready;
        any_push  = i_push.push_a || i_push.push_b;
        push_cnt  = CW'(i_push.push_a) + CW'(i_push.push_b);
        first_rec = i_push.push_a ? i_push.rec_a : i_push.rec_b;
        n_wr_ptr  = r_wr_ptr + AW'(push_cnt);
        n_count   = r_count + push_cnt - CW'(pop);
        o_valid   = r_count != '0;
        o_data    = r_mem[r_rd_ptr];
        // two free slots cover the worst case of one base
        o_room    = r_count <= CW'(hrc_pkg::QUEUE_DEPTH - 2);
    end

    always_ff @(posedge i_clk) begin
        if (any_push) begin
            r_mem[r_wr_ptr] <= first_rec;
        end
        if (i_push.push_a && i_push.push_b) begin
            r_mem[r_wr_ptr + AW'(1)] <= i_push.rec_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
        end
    end

endmodule

FILE: sim/tb_homopolymer_run_compressor.sv
module tb_homopolymer_run_compressor;

    // Cycles without any transfer before the run is declared hung
    localparam int unsigned STALL_LIMIT    = 2000;
    // Length of the long receiver hold-off used to back the block up
    localparam int unsigned RX_HOLD_CYCLES = 200;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    hrc_pkg::t_in  i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    hrc_pkg::t_out o_out_data;
    logic          i_cfg_we = 1'b0;
    logic [31:0]   i_cfg_wdata = '0;

    homopolymer_run_compressor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Bases waiting to be offered, and run records the block still owes us
    hrc_pkg::t_in  pending_bases [$];
    hrc_pkg::t_out expected_runs [$];

    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned error_count    = 0;
    int unsigned idle_cycles    = 0;
    bit          last_eos       = 1'b1;

    // Transfer flags, set at the rising edge; in_fire is read by the falling-edge input driver
    bit in_fire  = 1'b0;
    bit out_fire = 1'b0;

    // Traffic shaping, changed by the sequencer only right after a rising edge
    int unsigned send_idle_pct = 0;
    int unsigned rx_stall_pct  = 0;
    bit          rx_hold_req   = 1'b0;
    int unsigned rx_hold_left  = 0;

    // Shadow of the run tracker
    logic [31:0] cutoff_model = hrc_pkg::CUTOFF_RESET;
    logic [7:0]  cur_base     = '0;
    logic [31:0] run_len      = '0;
    logic [31:0] out_offset   = '0;
    bit          run_open     = 1'b0;

    // Close the open run: build its record and advance the compressed offset
    function automatic hrc_pkg::t_out close_run(bit final_rec);
        hrc_pkg::t_out rec;
        bit            coll;
        logic [31:0]   emitted;
        coll    = run_len > cutoff_model;
        emitted = coll ? 32'd1 : run_len;
        rec.run_base            = cur_base;
        rec.original_length     = run_len;
        rec.emitted_length      = emitted;
        rec.collapsed           = coll;
        rec.compressed_position = out_offset;
        rec.last_run            = final_rec;
        out_offset = out_offset + emitted;
        return rec;
    endfunction

    // Apply one accepted base; queue the zero, one or two records it closes
    task automatic predict_runs(hrc_pkg::t_in item);
        if (!run_open) begin
            cur_base = item.base;
            run_len  = 32'd1;
            run_open = 1'b1;
        end else if (item.base == cur_base) begin
            run_len = run_len + 32'd1;
        end else begin
            // A differing base closes the previous run first
            expected_runs = {expected_runs, close_run(1'b0)};
            cur_base = item.base;
            run_len  = 32'd1;
        end
        if (item.end_of_sequence) begin
            // Flush the current run and start the next sequence from offset zero
            expected_runs = {expected_runs, close_run(1'b1)};
            run_open   = 1'b0;
            cur_base   = '0;
            run_len    = '0;
            out_offset = '0;
        end
    endtask

    function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Monitor: check output transfers, predict on input transfers, watch for hangs
    always @(posedge i_clk) begin
        hrc_pkg::t_out exp_rec;
        in_fire  = i_rst_n && i_in_valid && o_in_ready;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        // Check before predicting so that a stray record never matches a fresh one
        if (out_fire) begin
            if (expected_runs.size() == 0) begin
                $error("run record with nothing expected: base %0h", o_out_data.run_base);
                error_count++;
            end else begin
                exp_rec = expected_runs.pop_front();
                cmp_field("run_base", exp_rec.run_base, o_out_data.run_base);
                cmp_field("original_length", exp_rec.original_length,
                          o_out_data.original_length);
                cmp_field("emitted_length", exp_rec.emitted_length,
                          o_out_data.emitted_length);
                cmp_field("collapsed", exp_rec.collapsed, o_out_data.collapsed);
                cmp_field("compressed_position", exp_rec.compressed_position,
                          o_out_data.compressed_position);
                cmp_field("last_run", exp_rec.last_run, o_out_data.last_run);
            end
        end
        if (in_fire) begin
            predict_runs(i_in_data);
            accepted_count++;
        end
        if (i_rst_n) begin
            idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Driver: hold a base until its transfer, then offer the next one or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_bases.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data  <= pending_bases.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request to fill the block
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic queue_base(logic [7:0] b, bit eos);
        hrc_pkg::t_in item;
        item.base            = b;
        item.end_of_sequence = eos;
        pending_bases = {pending_bases, item};
        queued_count++;
        last_eos = eos;
    endtask

    // Mostly well-formed sequences of runs, some loose noise bases;
    // always finish on an end-of-sequence so the block ends idle
    task automatic queue_random_items(int unsigned n);
        logic [7:0]  alphabet [4] = '{8'h41, 8'h43, 8'h47, 8'h54};
        int unsigned added = 0;
        int unsigned runs;
        int unsigned len;
        int unsigned r;
        logic [7:0]  b;
        while (added < n) begin
            if ($urandom_range(99) < 85) begin
                runs = $urandom_range(6, 1);
                for (int k = 0; k < runs; k++) begin
                    b = ($urandom_range(3) == 0) ? 8'($urandom) : alphabet[$urandom_range(3)];
                    r = $urandom_range(99);
                    len = (r < 80) ? $urandom_range(4, 1) :
                          (r < 95) ? $urandom_range(12, 5) : $urandom_range(40, 13);
                    for (int j = 0; j < len; j++)
                        queue_base(b, (k == runs - 1) && (j == len - 1));
                    added += len;
                end
            end else begin
                queue_base(8'($urandom), 1'($urandom_range(1)));
                added++;
            end
        end
        if (!last_eos)
            queue_base(8'($urandom), 1'b1);
    endtask

    // Wait until every base is taken and every record has come, then let it settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (accepted_count != queued_count || expected_runs.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cutoff(logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we     <= 1'b1;
        i_cfg_wdata  <= value;
        cutoff_model  = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Change traffic shaping right after a rising edge, clear of the drivers
    task automatic set_traffic(int unsigned send_pct, int unsigned rx_pct);
        @(posedge i_clk);
        send_idle_pct = send_pct;
        rx_stall_pct  = rx_pct;
    endtask

    // Sequencer
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset cutoff of one, no idling
        set_traffic(0, 0);
        queue_base(8'h41, 1'b1);                 // single-base sequence
        queue_base(8'h00, 1'b0);                 // run of two collapses
        queue_base(8'h00, 1'b1);
        queue_base(8'hFF, 1'b1);                 // top byte value
        queue_base(8'h41, 1'b0);                 // last base closes two runs
        queue_base(8'h41, 1'b0);
        queue_base(8'h43, 1'b1);
        queue_base(8'h47, 1'b0);
        queue_base(8'h54, 1'b0);
        queue_base(8'h54, 1'b0);
        queue_base(8'h54, 1'b0);
        queue_base(8'h41, 1'b0);
        queue_base(8'h41, 1'b1);
        queue_base(8'h43, 1'b0);                 // alternating single bases
        queue_base(8'h47, 1'b0);
        queue_base(8'h43, 1'b1);
        queue_base(8'h80, 1'b0);
        queue_base(8'h80, 1'b0);
        queue_base(8'h80, 1'b1);
        queue_base(8'h7F, 1'b1);
        wait_drained();

        // Cutoff zero: every run collapses, no idling
        write_cutoff(32'd0);
        set_traffic(0, 0);
        queue_random_items(120);
        wait_drained();

        // Cutoff at maximum: nothing collapses; sender mostly idle
        write_cutoff(32'hFFFF_FFFF);
        set_traffic(84, 0);
        queue_random_items(120);
        wait_drained();

        // Small cutoff; receiver mostly stalled, starting with a long hold-off
        // while the sender keeps offering so the input backs up
        write_cutoff(32'd3);
        set_traffic(0, 84);
        rx_hold_req = 1'b1;
        queue_random_items(120);
        wait_drained();

        // Random full-width cutoff; both sides idle now and then
        write_cutoff($urandom);
        set_traffic(17, 17);
        queue_random_items(120);
        wait_drained();

        // Random small cutoff, no idling; sender pauses halfway until drained
        write_cutoff($urandom_range(8, 2));
        set_traffic(0, 0);
        queue_random_items(65);
        wait_drained();
        queue_random_items(65);
        wait_drained();

        // Back to a cutoff of one; both sides idle now and then
        write_cutoff(32'd1);
        set_traffic(17, 17);
        queue_random_items(120);
        wait_drained();

        repeat (10) @(negedge i_clk);
        if (expected_runs.size() != 0) begin
            $error("%0d run records never arrived", expected_runs.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
src/hrc_pkg.sv
src/hrc_tracker.sv
src/hrc_queue.sv
src/homopolymer_run_compressor.sv
sim/tb_homopolymer_run_compressor.sv
